// ----- rtl/fec_pkg.sv -----
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types, constants and helpers for the file name extension classifier.
// ----------------------------------------------------------------------------
package fec_pkg;

  localparam int SuffixLen = 14;
  localparam int NameLenW  = 4;
  localparam logic [NameLenW-1:0] NameLenSat = 4'd15;
  localparam logic [7:0] CharDot = 8'h2E;

  // Extension text, first character in the most significant byte.
  typedef logic [3:0][7:0] ext_text_t;

  typedef struct packed {
    ext_text_t  txt;
    logic [2:0] len;
  } ext_entry_t;

  typedef struct packed {
    logic is_rom;
    logic is_descriptor;
    logic is_raw_track;
    logic is_launcher;
    logic is_core;
  } class_flags_t;

  localparam int RomCount    = 37;
  localparam int DescCount   = 4;
  localparam int RawCount    = 2;
  localparam int LaunchCount = 1;

  localparam ext_entry_t RomTable [RomCount] = '{
    '{{"bin", 8'h00}, 3'd3}, '{{"cue", 8'h00}, 3'd3}, '{{"img", 8'h00}, 3'd3},
    '{{"mdf", 8'h00}, 3'd3}, '{{"pbp", 8'h00}, 3'd3}, '{{"toc", 8'h00}, 3'd3},
    '{{"cbn", 8'h00}, 3'd3}, '{{"m3u", 8'h00}, 3'd3}, '{{"ccd", 8'h00}, 3'd3},
    '{{"chd", 8'h00}, 3'd3}, '{{"iso", 8'h00}, 3'd3}, '{{"exe", 8'h00}, 3'd3},
    '{{"sfc", 8'h00}, 3'd3}, '{{"smc", 8'h00}, 3'd3}, '{{"nes", 8'h00}, 3'd3},
    '{{"fds", 8'h00}, 3'd3}, '{{"gba", 8'h00}, 3'd3}, '{{"gb", 16'h0000}, 3'd2},
    '{{"gbc", 8'h00}, 3'd3}, '{{"md", 16'h0000}, 3'd2}, '{{"gen", 8'h00}, 3'd3},
    '{{"smd", 8'h00}, 3'd3}, '{{"32x", 8'h00}, 3'd3}, '{{"sms", 8'h00}, 3'd3},
    '{{"gg", 16'h0000}, 3'd2}, '{{"n64", 8'h00}, 3'd3}, '{{"z64", 8'h00}, 3'd3},
    '{{"v64", 8'h00}, 3'd3}, '{{"pce", 8'h00}, 3'd3}, '{{"ngp", 8'h00}, 3'd3},
    '{{"ws", 16'h0000}, 3'd2}, '{{"wsc", 8'h00}, 3'd3}, '{{"col", 8'h00}, 3'd3},
    '{{"a26", 8'h00}, 3'd3}, '{{"lnx", 8'h00}, 3'd3}, '{{"zip", 8'h00}, 3'd3},
    '{{"7z", 16'h0000}, 3'd2}
  };

  localparam ext_entry_t DescTable [DescCount] = '{
    '{{"cue", 8'h00}, 3'd3}, '{{"ccd", 8'h00}, 3'd3},
    '{{"toc", 8'h00}, 3'd3}, '{{"m3u", 8'h00}, 3'd3}
  };

  localparam ext_entry_t RawTable [RawCount] = '{
    '{{"bin", 8'h00}, 3'd3}, '{{"img", 8'h00}, 3'd3}
  };

  localparam ext_entry_t LaunchTable [LaunchCount] = '{
    '{"3dsx", 3'd4}
  };

  // Core suffix, oldest character in the most significant byte.
  localparam logic [SuffixLen-1:0][7:0] CoreSuffix = {
    8'h5F, 8'h6C, 8'h69, 8'h62, 8'h72, 8'h65, 8'h74,
    8'h72, 8'h6F, 8'h2E, 8'h33, 8'h64, 8'h73, 8'h78
  };

  // Lower-case fold for ASCII letters only.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic ext_equal(input ext_text_t head, input logic [3:0] len,
                                     input ext_entry_t e);
    logic ok;
    ok = ({1'b0, e.len} == len);
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < e.len && head[3-k] != e.txt[3-k]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ----- rtl/filename_extension_classifier.sv -----
// ----------------------------------------------------------------------------
// filename_extension_classifier
// Streams a file name one character per request and classifies its extension and its tail.
// ----------------------------------------------------------------------------
// The block accepts one character in every cycle unless the input stalls. Each
// request passes an input register, updates the extension buffer, tail window
// and length count, and on the request flagged as last the five classification
// flags are loaded from the input register stage into the result register. The
// state clears after each name. The input stalls only while a finished result
// waits and the character held in the input register closes another name.
module filename_extension_classifier #(
  parameter int MAX_EXT_LEN = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_rom_o,
  output logic       is_descriptor_o,
  output logic       is_raw_track_o,
  output logic       is_launcher_o,
  output logic       is_core_o
);

  localparam int LenW = $clog2(MAX_EXT_LEN + 1);
  localparam int SufW = fec_pkg::SuffixLen;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;

  logic [7:0]                     ext_buf_q [MAX_EXT_LEN];
  logic [7:0]                     ext_buf_d [MAX_EXT_LEN];
  logic [LenW-1:0]                ext_len_q, ext_len_d;
  logic                           ext_ovf_q, ext_ovf_d;
  logic                           seen_dot_q, seen_dot_d;
  logic [SufW-1:0][7:0]           tail_q, tail_d;
  logic [fec_pkg::NameLenW-1:0]   name_len_q, name_len_d;

  logic                  out_valid_q;
  fec_pkg::class_flags_t flags_d, flags_q;

  logic out_free, s1_go;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_go      = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
  end

  always_comb begin
    logic [7:0] folded;
    folded     = fec_pkg::fold(char_q);
    ext_buf_d  = ext_buf_q;
    ext_len_d  = ext_len_q;
    ext_ovf_d  = ext_ovf_q;
    seen_dot_d = seen_dot_q;
    if (char_q == fec_pkg::CharDot) begin
      seen_dot_d = 1'b1;
      ext_len_d  = '0;
      ext_ovf_d  = 1'b0;
      for (int i = 0; i < MAX_EXT_LEN; i++) begin
        ext_buf_d[i] = '0;
      end
    end else if (seen_dot_q) begin
      if (ext_len_q < LenW'(MAX_EXT_LEN)) begin
        for (int i = 0; i < MAX_EXT_LEN; i++) begin
          if (LenW'(i) == ext_len_q) begin
            ext_buf_d[i] = folded;
          end
        end
        ext_len_d = ext_len_q + 1'b1;
      end else begin
        ext_ovf_d = 1'b1;
      end
    end
    tail_d     = {tail_q[SufW-2:0], char_q};
    name_len_d = (name_len_q == fec_pkg::NameLenSat) ? name_len_q : name_len_q + 1'b1;
  end

  fec_classify #(
    .MAX_EXT_LEN(MAX_EXT_LEN)
  ) u_classify (
    .ext_buf_i  (ext_buf_d),
    .ext_len_i  (ext_len_d),
    .ext_ovf_i  (ext_ovf_d),
    .seen_dot_i (seen_dot_d),
    .tail_i     (tail_d),
    .name_len_i (name_len_d),
    .flags_o    (flags_d)
  );

  // Control state clears once the closing character has been classified.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_len_q  <= '0;
      ext_ovf_q  <= 1'b0;
      seen_dot_q <= 1'b0;
      name_len_q <= '0;
    end else if (s1_go) begin
      if (last_q) begin
        ext_len_q  <= '0;
        ext_ovf_q  <= 1'b0;
        seen_dot_q <= 1'b0;
        name_len_q <= '0;
      end else begin
        ext_len_q  <= ext_len_d;
        ext_ovf_q  <= ext_ovf_d;
        seen_dot_q <= seen_dot_d;
        name_len_q <= name_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      ext_buf_q <= ext_buf_d;
      tail_q    <= tail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && last_q) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_rom_o        = flags_q.is_rom;
  assign is_descriptor_o = flags_q.is_descriptor;
  assign is_raw_track_o  = flags_q.is_raw_track;
  assign is_launcher_o   = flags_q.is_launcher;
  assign is_core_o       = flags_q.is_core;

endmodule

// ----- rtl/fec_classify.sv -----
// ----------------------------------------------------------------------------
// fec_classify
// Table compare of the collected extension and the name tail.
// ----------------------------------------------------------------------------
module fec_classify #(
  parameter int MAX_EXT_LEN = 5,
  localparam int LenW = $clog2(MAX_EXT_LEN + 1)
) (
  input  logic [7:0]                             ext_buf_i [MAX_EXT_LEN],
  input  logic [LenW-1:0]                        ext_len_i,
  input  logic                                   ext_ovf_i,
  input  logic                                   seen_dot_i,
  input  logic [fec_pkg::SuffixLen-1:0][7:0]     tail_i,
  input  logic [fec_pkg::NameLenW-1:0]           name_len_i,
  output fec_pkg::class_flags_t                  flags_o
);

  fec_pkg::ext_text_t head;
  logic [3:0]         len4;
  logic               ext_ok;
  logic               rom_hit, desc_hit, raw_hit, launch_hit, core_hit;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      head[3-k] = ext_buf_i[k];
    end
    len4   = 4'(ext_len_i);
    ext_ok = seen_dot_i && !ext_ovf_i;

    rom_hit = 1'b0;
    for (int i = 0; i < fec_pkg::RomCount; i++) begin
      rom_hit |= fec_pkg::ext_equal(head, len4, fec_pkg::RomTable[i]);
    end
    desc_hit = 1'b0;
    for (int i = 0; i < fec_pkg::DescCount; i++) begin
      desc_hit |= fec_pkg::ext_equal(head, len4, fec_pkg::DescTable[i]);
    end
    raw_hit = 1'b0;
    for (int i = 0; i < fec_pkg::RawCount; i++) begin
      raw_hit |= fec_pkg::ext_equal(head, len4, fec_pkg::RawTable[i]);
    end
    launch_hit = 1'b0;
    for (int i = 0; i < fec_pkg::LaunchCount; i++) begin
      launch_hit |= fec_pkg::ext_equal(head, len4, fec_pkg::LaunchTable[i]);
    end

    // The saturated count means the name is longer than the suffix.
    core_hit = (name_len_i == fec_pkg::NameLenSat);
    for (int k = 0; k < fec_pkg::SuffixLen; k++) begin
      if (fec_pkg::fold(tail_i[k]) != fec_pkg::CoreSuffix[k]) begin
        core_hit = 1'b0;
      end
    end

    flags_o.is_rom        = ext_ok && rom_hit;
    flags_o.is_descriptor = ext_ok && desc_hit;
    flags_o.is_raw_track  = ext_ok && raw_hit;
    flags_o.is_launcher   = ext_ok && launch_hit;
    flags_o.is_core       = core_hit;
  end

endmodule
